>>> hw/rtl/ctl_pkg.sv
// ---------------------------------------------------------------------------
// ctl_pkg: shared types and constants for the configuration text lexer
// Token record layout, scanner states, character codes and class helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package ctl_pkg;

    // A stream holds at most this many bytes; one more byte is an error.
    localparam logic [16:0] STREAM_LIMIT = 17'd65535;

    // Queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_EQUALS = 8'h3d;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;

    // Scanner states.
    typedef enum logic [3:0] {
        S_INIT    = 4'd0,
        S_ID      = 4'd1,
        S_STRCONT = 4'd2,
        S_STRESC  = 4'd3,
        S_NEG     = 4'd5,
        S_INT     = 4'd6,
        S_WS      = 4'd7,
        S_COM     = 4'd8,
        S_FAILED  = 4'd9
    } t_lex_state;

    // Token kinds.
    typedef enum logic [3:0] {
        K_ID   = 4'd0,
        K_STR  = 4'd1,
        K_INT  = 4'd2,
        K_LB   = 4'd3,
        K_RB   = 4'd4,
        K_EQ   = 4'd5,
        K_SEMI = 4'd6,
        K_EOF  = 4'd7,
        K_ERR  = 4'd8
    } t_tok_kind;

    // One token record.
    typedef struct packed {
        t_tok_kind   kind;
        logic [15:0] start;
        logic [15:0] raw_len;
        logic [15:0] val_len;
        logic [16:0] err_pos;
        logic        last;
    } t_token;

    // Records caused by one input item: one, or two when two is set.
    typedef struct packed {
        t_token rec0;
        t_token rec1;
        logic   two;
    } t_tok_pair;

    function automatic t_token make_rec(input t_tok_kind kind, input logic [15:0] start,
                                        input logic [15:0] raw_len,
                                        input logic [15:0] val_len,
                                        input logic [16:0] err_pos, input logic last);
        t_token r;
        r.kind    = kind;
        r.start   = start;
        r.raw_len = raw_len;
        r.val_len = val_len;
        r.err_pos = err_pos;
        r.last    = last;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ctl_front.sv
// ---------------------------------------------------------------------------
// ctl_front: scanner front end
// Accepts one byte or end marker per cycle while the queue has room, runs the
// lexer state machine and pushes each item's token records into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module ctl_front
    import ctl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire logic      i_cmd,
    input  wire logic [7:0] i_data_byte,
    input  wire logic      i_q_full,
    output logic           o_push,
    output t_tok_pair      o_pair
);

    t_lex_state  r_state, n_state;
    logic [16:0] r_byte_count, n_byte_count;
    logic [15:0] r_token_begin, n_token_begin;
    logic [15:0] r_clean_count, n_clean_count;

    logic        accept;
    logic [7:0]  c;
    logic        overflow;
    logic [16:0] pos_plus1;
    logic [15:0] len;
    logic        rescan;
    logic        is_idch;
    logic        is_nz_digit;

    // Scan of the byte from the initial state.
    t_lex_state  scan_state;
    logic        scan_emit;
    t_tok_kind   scan_kind;
    logic        scan_fail;
    logic        scan_str;

    t_token      rec_a, rec_b;
    logic        a_vld, b_vld;

    assign o_ready     = !i_q_full;
    assign accept      = i_valid && o_ready;
    assign c           = i_data_byte;
    assign overflow    = r_byte_count >= STREAM_LIMIT;
    assign pos_plus1   = r_byte_count + 17'd1;
    assign len         = r_byte_count[15:0] - r_token_begin;
    assign is_idch     = is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT;
    assign is_nz_digit = c >= CH_ONE && c <= CH_NINE;

    // A pending identifier, integer or whitespace run ends here, or no token
    // is open: the byte is then scanned from the initial state.
    always_comb begin
        unique case (r_state)
            S_INIT:  rescan = 1'b1;
            S_ID:    rescan = !is_idch;
            S_INT:   rescan = !is_digit(c);
            S_WS:    rescan = !is_ws(c);
            default: rescan = 1'b0;
        endcase
    end

    // Initial-state character decode.
    always_comb begin
        scan_state = S_INIT;
        scan_emit  = 1'b0;
        scan_kind  = K_ID;
        scan_fail  = 1'b0;
        scan_str   = 1'b0;
        if (is_alpha(c) || c == CH_UNDER) begin
            scan_state = S_ID;
        end else if (c == CH_QUOTE) begin
            scan_state = S_STRCONT;
            scan_str   = 1'b1;
        end else if (c == CH_ZERO) begin
            scan_emit = 1'b1;
            scan_kind = K_INT;
        end else if (is_digit(c)) begin
            scan_state = S_INT;
        end else if (c == CH_MINUS) begin
            scan_state = S_NEG;
        end else if (c == CH_LBRACE) begin
            scan_emit = 1'b1;
            scan_kind = K_LB;
        end else if (c == CH_RBRACE) begin
            scan_emit = 1'b1;
            scan_kind = K_RB;
        end else if (c == CH_EQUALS) begin
            scan_emit = 1'b1;
            scan_kind = K_EQ;
        end else if (c == CH_SEMI) begin
            scan_emit = 1'b1;
            scan_kind = K_SEMI;
        end else if (is_ws(c)) begin
            scan_state = S_WS;
        end else if (c == CH_HASH) begin
            scan_state = S_COM;
        end else begin
            scan_fail = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state       = r_state;
        n_byte_count  = r_byte_count;
        n_token_begin = r_token_begin;
        n_clean_count = r_clean_count;
        if (accept) begin
            if (i_cmd) begin
                // The end marker always starts a fresh stream.
                n_state       = S_INIT;
                n_byte_count  = '0;
                n_token_begin = '0;
                n_clean_count = '0;
            end else if (r_state != S_FAILED) begin
                if (overflow) begin
                    n_state = S_FAILED;
                end else begin
                    n_byte_count = pos_plus1;
                    if (rescan) begin
                        n_token_begin = r_byte_count[15:0];
                        n_state       = scan_fail ? S_FAILED : scan_state;
                        if (scan_str) begin
                            n_clean_count = '0;
                        end
                    end else begin
                        unique case (r_state)
                            S_COM: begin
                                if (c == CH_CR || c == CH_LF) begin
                                    n_state = S_INIT;
                                end
                            end
                            S_STRCONT: begin
                                if (c == CH_BSLASH) begin
                                    n_state = S_STRESC;
                                end else if (c == CH_QUOTE) begin
                                    n_state = S_INIT;
                                end else begin
                                    n_clean_count = r_clean_count + 16'd1;
                                end
                            end
                            S_STRESC: begin
                                if (c == CH_BSLASH || c == CH_QUOTE) begin
                                    n_clean_count = r_clean_count + 16'd1;
                                    n_state       = S_STRCONT;
                                end else begin
                                    n_state = S_FAILED;
                                end
                            end
                            S_NEG: begin
                                n_state = is_nz_digit ? S_INT : S_FAILED;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Records: rec_a is the closing token or a state error, rec_b the token
    // or error found by the initial-state scan, or the EOF record.
    always_comb begin
        a_vld = 1'b0;
        b_vld = 1'b0;
        rec_a = make_rec(K_ERR, '0, '0, '0, pos_plus1, 1'b1);
        rec_b = make_rec(K_ERR, '0, '0, '0, pos_plus1, 1'b1);
        if (i_cmd) begin
            unique case (r_state)
                S_FAILED: begin
                end
                S_STRCONT, S_STRESC, S_NEG: begin
                    a_vld = 1'b1;
                end
                S_ID, S_INT: begin
                    a_vld = 1'b1;
                    rec_a = make_rec((r_state == S_ID) ? K_ID : K_INT, r_token_begin,
                                     len, len, '0, 1'b0);
                    b_vld = 1'b1;
                    rec_b = make_rec(K_EOF, r_byte_count[15:0], '0, '0, '0, 1'b1);
                end
                default: begin
                    b_vld = 1'b1;
                    rec_b = make_rec(K_EOF, r_byte_count[15:0], '0, '0, '0, 1'b1);
                end
            endcase
        end else if (r_state != S_FAILED) begin
            if (overflow) begin
                a_vld = 1'b1;
            end else begin
                unique case (r_state)
                    S_ID, S_INT: begin
                        if (rescan) begin
                            a_vld = 1'b1;
                            rec_a = make_rec((r_state == S_ID) ? K_ID : K_INT,
                                             r_token_begin, len, len, '0, 1'b0);
                        end
                    end
                    S_STRCONT: begin
                        if (c == CH_QUOTE) begin
                            a_vld = 1'b1;
                            rec_a = make_rec(K_STR, r_token_begin, len + 16'd1,
                                             r_clean_count, '0, 1'b0);
                        end
                    end
                    S_STRESC: begin
                        a_vld = !(c == CH_BSLASH || c == CH_QUOTE);
                    end
                    S_NEG: begin
                        a_vld = !is_nz_digit;
                    end
                    default: begin
                    end
                endcase
                if (rescan) begin
                    if (scan_fail) begin
                        b_vld = 1'b1;
                    end else if (scan_emit) begin
                        b_vld = 1'b1;
                        rec_b = make_rec(scan_kind, r_byte_count[15:0], 16'd1, 16'd1,
                                         '0, 1'b0);
                    end
                end
            end
        end
    end

    // Pack the records in order; an item with no record pushes nothing.
    assign o_pair.rec0 = a_vld ? rec_a : rec_b;
    assign o_pair.rec1 = rec_b;
    assign o_pair.two  = a_vld && b_vld;
    assign o_push      = accept && (a_vld || b_vld);

    // Scanner registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_byte_count  <= '0;
            r_token_begin <= '0;
            r_clean_count <= '0;
        end else begin
            r_state       <= n_state;
            r_byte_count  <= n_byte_count;
            r_token_begin <= n_token_begin;
            r_clean_count <= n_clean_count;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ctl_queue.sv
// ---------------------------------------------------------------------------
// ctl_queue: record queue
// Short first-in first-out store of record pairs between scanner and output.
// ---------------------------------------------------------------------------
`default_nettype none

module ctl_queue
    import ctl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_tok_pair i_pair,
    input  wire logic      i_pop,
    output t_tok_pair      o_head,
    output logic           o_empty,
    output logic           o_full
);

    t_tok_pair          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_empty = r_count == '0;
    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ctl_back.sv
// ---------------------------------------------------------------------------
// ctl_back: output stage
// Holds one record pair and hands its records out one per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module ctl_back
    import ctl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_empty,
    input  wire t_tok_pair i_q_head,
    output logic           o_q_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_token         o_rec
);

    t_tok_pair r_pair;
    logic      r_full;
    logic      r_idx;
    logic      last_of_pair;
    logic      done;

    assign last_of_pair = !r_pair.two || r_idx;
    assign done         = r_full && i_ready && last_of_pair;
    assign o_q_pop      = !i_q_empty && (!r_full || done);
    assign o_valid      = r_full;
    assign o_rec        = r_idx ? r_pair.rec1 : r_pair.rec0;

    // Pair payload.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pair <= i_q_head;
        end
    end

    // Occupancy and record select.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= 1'b0;
        end else if (o_q_pop) begin
            r_full <= 1'b1;
            r_idx  <= 1'b0;
        end else if (done) begin
            r_full <= 1'b0;
            r_idx  <= 1'b0;
        end else if (r_full && i_ready) begin
            r_idx <= 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/config_text_lexer.sv
// Path: each record is written into the record queue and then loaded into the
// output stage register before it is offered on the output.
// Throughput: one input item per cycle while the record queue has room; the
// output stage delivers one record per cycle while i_ready is high, so an item
// causing two records holds the output for both transfers and the four-entry queue absorbs bursts.
// Reset: synchronous, active low; clears scanner state, queue and output stage.
// ---------------------------------------------------------------------------
// config_text_lexer: streaming lexer for a small configuration language
// Scanner front end, record queue and output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module config_text_lexer
    import ctl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_token_kind,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_raw_length,
    output logic [15:0]      o_value_length,
    output logic [16:0]      o_error_position,
    output logic             o_last
);

    logic      q_push;
    logic      q_pop;
    logic      q_empty;
    logic      q_full;
    t_tok_pair push_pair;
    t_tok_pair q_head;
    t_token    out_rec;

    // Scanner.
    ctl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_pair      (push_pair)
    );

    // Record queue.
    ctl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pair  (push_pair),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Output stage.
    ctl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rec     (out_rec)
    );

    assign o_token_kind     = out_rec.kind;
    assign o_token_start    = out_rec.start;
    assign o_raw_length     = out_rec.raw_len;
    assign o_value_length   = out_rec.val_len;
    assign o_error_position = out_rec.err_pos;
    assign o_last           = out_rec.last;

    // The scanner never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("record pushed into full queue");

    // The output stage never pops an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("record popped from empty queue");

    // An EOF record always closes the stream.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind == K_EOF) |-> o_last)
        else $error("EOF record without last");

    // An error record closes the stream and carries a nonzero position.
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind == K_ERR) |-> (o_last && o_error_position != '0))
        else $error("malformed error record");

endmodule

`default_nettype wire

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking testbench for config_text_lexer
// Sends byte and end-marker transfers in bursts with random gaps while the
// record side stalls on changing patterns. Each record is checked against the
// bench's scanner model, checked table rows against their own record: a short
// directed table first, then random streams of well-formed and broken text.
// ---------------------------------------------------------------------------
module tb;
    import ctl_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 100;

    typedef enum {
        CC_LETTER, CC_UNDER, CC_DOT, CC_ZERO, CC_DIGIT, CC_BLANK, CC_EOL, CC_QUOTE,
        CC_BSLASH, CC_MINUS, CC_HASH, CC_LBRACE, CC_RBRACE, CC_EQUALS, CC_SEMI, CC_OTHER
    } t_char_cls;

    typedef enum {RDY_FULL, RDY_MOSTLY, RDY_PATTERN, RDY_SPARSE} t_ready_mode;

    typedef enum {PC_IDENT, PC_STRING, PC_INT, PC_PUNCT, PC_SPACE, PC_COMMENT} t_piece;

    // One line of the directed table; rec is used only when typed is set.
    typedef struct packed {
        logic       cmd;
        logic [7:0] c;
        logic       typed;
        t_token     rec;
    } t_dir_row;

    // Stimulus side.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_cmd       = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_ready     = 1'b0;

    // Record side.
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [15:0] o_raw_length;
    logic [15:0] o_value_length;
    logic [16:0] o_error_position;
    logic        o_last;

    // Scanner model state.
    t_lex_state  lex_st     = S_INIT;
    logic [16:0] bytes_seen = 17'd0;
    logic [15:0] tok_origin = 16'd0;
    logic [15:0] str_chars  = 16'd0;

    t_token     tokens_due[$];
    t_token     step_recs[$];
    logic [7:0] text_q[$];
    t_dir_row   dir_rows[$];

    int mismatches   = 0;
    int records_seen = 0;
    int live_items   = 0;
    int burst_left   = 0;
    int cycle_count  = 0;

    config_text_lexer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_token_kind    (o_token_kind),
        .o_token_start   (o_token_start),
        .o_raw_length    (o_raw_length),
        .o_value_length  (o_value_length),
        .o_error_position(o_error_position),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic t_token error_rec(input logic [16:0] where);
        return make_rec(K_ERR, 16'd0, 16'd0, 16'd0, where, 1'b1);
    endfunction

    function automatic logic [7:0] letter_of(input int r);
        return (r < 26) ? 8'h61 + 8'(r) : 8'h41 + 8'(r - 26);
    endfunction

    // Random byte with NUL and 0xFF made more likely.
    function automatic logic [7:0] raw_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("record %0d %s: got %0h, expected %0h", records_seen, what, got, want);
        mismatches++;
    endtask

    // Expected records for one accepted item; they land in step_recs.
    task automatic predict_tokens(input logic cmd, input logic [7:0] c);
        logic [16:0] pos;
        logic [15:0] run_len;
        t_char_cls   cls;
        logic        rescan;
        logic        bad;
        step_recs.delete();
        if (cmd) begin
            // End marker: close what is open, then start a fresh stream.
            run_len = bytes_seen[15:0] - tok_origin;
            if (lex_st == S_STRCONT || lex_st == S_STRESC || lex_st == S_NEG) begin
                step_recs.push_back(error_rec(bytes_seen + 17'd1));
            end else if (lex_st != S_FAILED) begin
                if (lex_st == S_ID)
                    step_recs.push_back(make_rec(K_ID, tok_origin, run_len, run_len,
                                                 17'd0, 1'b0));
                else if (lex_st == S_INT)
                    step_recs.push_back(make_rec(K_INT, tok_origin, run_len, run_len,
                                                 17'd0, 1'b0));
                step_recs.push_back(make_rec(K_EOF, bytes_seen[15:0], 16'd0, 16'd0,
                                             17'd0, 1'b1));
            end
            lex_st     = S_INIT;
            bytes_seen = 17'd0;
            tok_origin = 16'd0;
            str_chars  = 16'd0;
        end else if (lex_st != S_FAILED) begin
            if (bytes_seen >= STREAM_LIMIT) begin
                // Offset overflow drops any pending token.
                step_recs.push_back(error_rec(bytes_seen + 17'd1));
                lex_st = S_FAILED;
            end else begin
                pos        = bytes_seen;
                bytes_seen = bytes_seen + 17'd1;
                run_len    = pos[15:0] - tok_origin;

                // Character class; NUL falls into CC_OTHER.
                if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                    cls = CC_LETTER;
                else if (c >= CH_ONE && c <= CH_NINE)
                    cls = CC_DIGIT;
                else begin
                    case (c)
                        CH_ZERO:         cls = CC_ZERO;
                        CH_UNDER:        cls = CC_UNDER;
                        CH_DOT:          cls = CC_DOT;
                        CH_SPACE, CH_TAB: cls = CC_BLANK;
                        CH_CR, CH_LF:    cls = CC_EOL;
                        CH_QUOTE:        cls = CC_QUOTE;
                        CH_BSLASH:       cls = CC_BSLASH;
                        CH_MINUS:        cls = CC_MINUS;
                        CH_HASH:         cls = CC_HASH;
                        CH_LBRACE:       cls = CC_LBRACE;
                        CH_RBRACE:       cls = CC_RBRACE;
                        CH_EQUALS:       cls = CC_EQUALS;
                        CH_SEMI:         cls = CC_SEMI;
                        default:         cls = CC_OTHER;
                    endcase
                end

                // A byte that closes an identifier, integer or blank run is
                // scanned again from the initial state.
                bad    = 1'b0;
                rescan = 1'b1;
                while (rescan && !bad) begin
                    rescan = 1'b0;
                    case (lex_st)
                        S_ID: begin
                            if (!(cls == CC_LETTER || cls == CC_UNDER || cls == CC_DOT ||
                                  cls == CC_ZERO || cls == CC_DIGIT)) begin
                                step_recs.push_back(make_rec(K_ID, tok_origin, run_len,
                                                             run_len, 17'd0, 1'b0));
                                lex_st = S_INIT;
                                rescan = 1'b1;
                            end
                        end
                        S_INT: begin
                            if (!(cls == CC_ZERO || cls == CC_DIGIT)) begin
                                step_recs.push_back(make_rec(K_INT, tok_origin, run_len,
                                                             run_len, 17'd0, 1'b0));
                                lex_st = S_INIT;
                                rescan = 1'b1;
                            end
                        end
                        S_WS: begin
                            if (!(cls == CC_BLANK || cls == CC_EOL)) begin
                                lex_st = S_INIT;
                                rescan = 1'b1;
                            end
                        end
                        S_COM: begin
                            if (cls == CC_EOL)
                                lex_st = S_INIT;
                        end
                        S_STRCONT: begin
                            if (cls == CC_BSLASH) begin
                                lex_st = S_STRESC;
                            end else if (cls == CC_QUOTE) begin
                                step_recs.push_back(make_rec(K_STR, tok_origin,
                                                             run_len + 16'd1, str_chars,
                                                             17'd0, 1'b0));
                                lex_st = S_INIT;
                            end else begin
                                str_chars = str_chars + 16'd1;
                            end
                        end
                        S_STRESC: begin
                            if (cls == CC_BSLASH || cls == CC_QUOTE) begin
                                str_chars = str_chars + 16'd1;
                                lex_st    = S_STRCONT;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        S_NEG: begin
                            if (cls == CC_DIGIT)
                                lex_st = S_INT;
                            else
                                bad = 1'b1;
                        end
                        default: begin
                            tok_origin = pos[15:0];
                            case (cls)
                                CC_LETTER, CC_UNDER: lex_st = S_ID;
                                CC_QUOTE: begin
                                    str_chars = 16'd0;
                                    lex_st    = S_STRCONT;
                                end
                                CC_ZERO: step_recs.push_back(make_rec(K_INT, pos[15:0], 16'd1,
                                                                      16'd1, 17'd0, 1'b0));
                                CC_DIGIT: lex_st = S_INT;
                                CC_MINUS: lex_st = S_NEG;
                                CC_LBRACE: step_recs.push_back(make_rec(K_LB, pos[15:0], 16'd1,
                                                                        16'd1, 17'd0, 1'b0));
                                CC_RBRACE: step_recs.push_back(make_rec(K_RB, pos[15:0], 16'd1,
                                                                        16'd1, 17'd0, 1'b0));
                                CC_EQUALS: step_recs.push_back(make_rec(K_EQ, pos[15:0], 16'd1,
                                                                        16'd1, 17'd0, 1'b0));
                                CC_SEMI: step_recs.push_back(make_rec(K_SEMI, pos[15:0], 16'd1,
                                                                      16'd1, 17'd0, 1'b0));
                                CC_BLANK, CC_EOL: lex_st = S_WS;
                                CC_HASH: lex_st = S_COM;
                                default: bad = 1'b1;
                            endcase
                        end
                    endcase
                end

                if (bad) begin
                    step_recs.push_back(error_rec(pos + 17'd1));
                    lex_st = S_FAILED;
                end
            end
        end
    endtask

    // Sends one item in bursts with random gaps, then records what it should cause.
    task automatic push_item(input logic cmd, input logic [7:0] c, input logic typed,
                             input t_token want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_data_byte <= c;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (cmd || lex_st != S_FAILED)
            live_items++;
        predict_tokens(cmd, c);
        if (typed)
            tokens_due.push_back(want);
        else
            foreach (step_recs[k])
                tokens_due.push_back(step_recs[k]);
    endtask

    task automatic add_row(input logic cmd, input logic [7:0] c);
        dir_rows.push_back('{cmd: cmd, c: c, typed: 1'b0, rec: '0});
    endtask

    task automatic add_checked(input logic cmd, input logic [7:0] c, input t_token rec);
        dir_rows.push_back('{cmd: cmd, c: c, typed: 1'b1, rec: rec});
    endtask

    // Appends one lexical piece with random content to text_q.
    task automatic add_piece(input t_piece what);
        int         n;
        int         r;
        logic [7:0] b;
        case (what)
            PC_IDENT: begin
                r = $urandom_range(0, 52);
                text_q.push_back((r == 52) ? CH_UNDER : letter_of(r));
                n = $urandom_range(0, 7);
                repeat (n) begin
                    r = $urandom_range(0, 65);
                    if (r < 52)
                        text_q.push_back(letter_of(r));
                    else if (r < 62)
                        text_q.push_back(CH_ZERO + 8'(r - 52));
                    else if (r < 64)
                        text_q.push_back(CH_UNDER);
                    else
                        text_q.push_back(CH_DOT);
                end
            end
            PC_STRING: begin
                text_q.push_back(CH_QUOTE);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back($urandom_range(0, 1) ? CH_BSLASH : CH_QUOTE);
                    end else begin
                        b = raw_byte();
                        while (b == CH_QUOTE || b == CH_BSLASH)
                            b = raw_byte();
                        text_q.push_back(b);
                    end
                end
                text_q.push_back(CH_QUOTE);
            end
            PC_INT: begin
                if ($urandom_range(0, 3) == 0) begin
                    text_q.push_back(CH_ZERO);
                end else begin
                    if ($urandom_range(0, 2) == 0)
                        text_q.push_back(CH_MINUS);
                    text_q.push_back(CH_ONE + 8'($urandom_range(0, 8)));
                    n = $urandom_range(0, 4);
                    repeat (n)
                        text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                end
            end
            PC_PUNCT: begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(CH_LBRACE);
                    1: text_q.push_back(CH_RBRACE);
                    2: text_q.push_back(CH_EQUALS);
                    default: text_q.push_back(CH_SEMI);
                endcase
            end
            PC_SPACE: begin
                n = $urandom_range(1, 3);
                repeat (n)
                    text_q.push_back(blank_byte());
            end
            default: begin
                text_q.push_back(CH_HASH);
                n = $urandom_range(0, 10);
                repeat (n) begin
                    b = raw_byte();
                    while (b == CH_CR || b == CH_LF)
                        b = raw_byte();
                    text_q.push_back(b);
                end
                text_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
        endcase
    endtask

    // Builds the text of one random stream: mostly well-formed, some with a
    // stray byte, some with a broken or unfinished construct at the end, some pure noise.
    task automatic compose_stream();
        int style;
        int pieces;
        int noise_at;
        text_q.delete();
        style = $urandom_range(0, 9);
        if (style == 9) begin
            pieces = $urandom_range(1, 10);
            repeat (pieces)
                text_q.push_back(raw_byte());
            return;
        end
        pieces   = $urandom_range(2, 14);
        noise_at = $urandom_range(0, pieces - 1);
        for (int k = 0; k < pieces; k++) begin
            if (style == 7 && k == noise_at)
                text_q.push_back(raw_byte());
            add_piece(t_piece'($urandom_range(0, 5)));
            if ($urandom_range(0, 9) < 4)
                add_piece(PC_SPACE);
        end
        if (style == 8) begin
            case ($urandom_range(0, 4))
                // String without its closing quote.
                0: begin
                    add_piece(PC_STRING);
                    text_q.delete(text_q.size() - 1);
                end
                // Stream ends right after a backslash inside a string.
                1: begin
                    text_q.push_back(CH_QUOTE);
                    text_q.push_back(CH_BSLASH);
                end
                // Lone minus at the end.
                2: text_q.push_back(CH_MINUS);
                // Minus followed by a random byte and an identifier.
                3: begin
                    text_q.push_back(CH_MINUS);
                    text_q.push_back(raw_byte());
                    add_piece(PC_IDENT);
                end
                // Backslash followed by an arbitrary byte.
                default: begin
                    text_q.push_back(CH_QUOTE);
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(raw_byte());
                    add_piece(PC_INT);
                end
            endcase
        end
    endtask

    // Record-side stall patterns, switched at random.
    t_ready_mode ready_mode = RDY_FULL;
    int          mode_left  = 0;
    logic [7:0]  stall_pat  = 8'b1101_0110;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        stall_pat <= {stall_pat[6:0], stall_pat[7]};
        case (ready_mode)
            RDY_FULL:    i_ready <= 1'b1;
            RDY_MOSTLY:  i_ready <= ($urandom_range(0, 9) < 7);
            RDY_PATTERN: i_ready <= stall_pat[0];
            default:     i_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // Compare each record transfer with the oldest expected token.
    t_token due_rec;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (tokens_due.size() == 0) begin
                flag_mismatch("with nothing expected, kind", 32'(o_token_kind), 32'd0);
            end else begin
                due_rec = tokens_due.pop_front();
                if (o_token_kind !== due_rec.kind)
                    flag_mismatch("token_kind", 32'(o_token_kind), 32'(due_rec.kind));
                if (o_token_start !== due_rec.start)
                    flag_mismatch("token_start", 32'(o_token_start), 32'(due_rec.start));
                if (o_raw_length !== due_rec.raw_len)
                    flag_mismatch("raw_length", 32'(o_raw_length), 32'(due_rec.raw_len));
                if (o_value_length !== due_rec.val_len)
                    flag_mismatch("value_length", 32'(o_value_length),
                                  32'(due_rec.val_len));
                if (o_error_position !== due_rec.err_pos)
                    flag_mismatch("error_position", 32'(o_error_position),
                                  32'(due_rec.err_pos));
                if (o_last !== due_rec.last)
                    flag_mismatch("last", 32'(o_last), 32'(due_rec.last));
            end
            records_seen++;
        end
    end

    // Main sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty stream straight after reset.
        add_checked(1'b1, 8'h00, make_rec(K_EOF, 16'd0, 16'd0, 16'd0, 17'd0, 1'b1));

        // Brace, identifier with dot and digit closed by a NUL, which is then
        // illegal as a token start; later bytes and the end marker are silent.
        add_checked(1'b0, CH_LBRACE, make_rec(K_LB, 16'd0, 16'd1, 16'd1, 17'd0, 1'b0));
        add_row(1'b0, "a");
        add_row(1'b0, CH_DOT);
        add_row(1'b0, "9");
        add_row(1'b0, 8'h00);
        add_row(1'b0, 8'hff);
        add_row(1'b1, 8'hff);

        // Underscore identifier closed by a blank, comment holding a NUL,
        // negative integer closed by equals, string with an escaped backslash and a NUL,
        // single-byte tokens, lone zero, and an integer flushed by the end.
        add_row(1'b0, CH_UNDER);
        add_row(1'b0, CH_SPACE);
        add_row(1'b0, CH_HASH);
        add_row(1'b0, 8'h00);
        add_row(1'b0, CH_LF);
        add_row(1'b0, CH_MINUS);
        add_row(1'b0, "7");
        add_row(1'b0, CH_EQUALS);
        add_row(1'b0, CH_QUOTE);
        add_row(1'b0, CH_BSLASH);
        add_row(1'b0, CH_BSLASH);
        add_row(1'b0, 8'h00);
        add_row(1'b0, CH_QUOTE);
        add_checked(1'b0, CH_RBRACE, make_rec(K_RB, 16'd13, 16'd1, 16'd1, 17'd0, 1'b0));
        add_checked(1'b0, CH_SEMI, make_rec(K_SEMI, 16'd14, 16'd1, 16'd1, 17'd0, 1'b0));
        add_checked(1'b0, CH_ZERO, make_rec(K_INT, 16'd15, 16'd1, 16'd1, 17'd0, 1'b0));
        add_row(1'b0, "4");
        add_row(1'b1, 8'h00);

        // End marker inside an open string.
        add_row(1'b0, CH_QUOTE);
        add_checked(1'b1, 8'h00, error_rec(17'd2));

        foreach (dir_rows[k])
            push_item(dir_rows[k].cmd, dir_rows[k].c, dir_rows[k].typed, dir_rows[k].rec);

        // Random streams, each closed by an end marker with a random payload.
        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            compose_stream();
            foreach (text_q[k])
                push_item(1'b0, text_q[k], 1'b0, '0);
            push_item(1'b1, raw_byte(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
